>>> design/nws_pkg.sv
// Package for the weighted-sum neuron with sigmoid output.
// Holds shared widths, the pipeline flag type and the sigmoid table builders.
// No dependencies.
`default_nettype none

package nws_pkg;

    localparam int ACC_W   = 48;
    localparam int IN_W    = 24;
    localparam int OUT_W   = 17;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 24;

    localparam logic [OUT_W-1:0] ONE_Q16 = 17'd65536;

    typedef logic signed [ACC_W-1:0] acc_t;

    typedef struct packed {
        logic below;
        logic above;
        logic neg;
        logic sat;
    } sig_flags_t;

    // unsigned quotient by shift and subtract
    function automatic longint unsigned udiv(longint unsigned num, longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        int              b;
        quo = '0;
        rem = '0;
        for (b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // e^-h in Q30 from a series truncated after the h^24 term
    function automatic longint unsigned exp_step(longint unsigned h);
        longint unsigned term;
        longint signed   acc;
        int              n;
        term = 64'd1 << 30;
        acc  = 64'sd1 << 30;
        for (n = 1; n <= 24; n++) begin
            term = udiv((term * h) >> 30, longint'(n));
            if (n % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        return (acc > 0) ? longint'(acc) : 64'd0;
    endfunction

    // table entry k: round(2^16 / (1 + q^k)), q^k in Q30
    function automatic logic [OUT_W-1:0] sig_entry(longint unsigned q, int unsigned k);
        longint unsigned p;
        longint unsigned den;
        int unsigned     i;
        p = 64'd1 << 30;
        for (i = 0; i < k; i++) begin
            p = (p * q + (64'd1 << 29)) >> 30;
        end
        den = (64'd1 << 30) + p;
        return OUT_W'(udiv((64'd1 << 46) + den / 64'd2, den));
    endfunction

endpackage

`default_nettype wire

>>> design/neuron_weighted_sum_sigmoid.sv
// Neuron: multiply-accumulate of weight * source value, sigmoid on list end.
// Depends on nws_pkg (widths, flag struct, sigmoid table builders).
// Sigmoid table is a ROM with registered two-port read.
//
//  channel | dir | tdata                               | tuser          | tlast
//  s_      | in  | weight[23:0], source_value[47:24]   | -              | last_connection
//  m_      | out | neuron_value[16:0], zero pad        | sum_saturated  | -
//
// Items without last are taken one per cycle while input is not held off (24x24
// multiply, then 48-bit saturating add). An item with last is taken, and input
// holds off until its result reaches the output register or skid entry. The
// sigmoid path runs through registered steps: abs/compare, segment multiply,
// ROM read, interpolation multiply.
// Reset (aresetn low, synchronous) clears the sum, saturation flag and all valids.
// Input also holds off while two results wait at the output.
`default_nettype none

module neuron_weighted_sum_sigmoid #(
    parameter int FRAC_BITS        = 16,
    parameter int SIGMOID_SEGMENTS = 64
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [nws_pkg::S_DATA_W-1:0] s_tdata,   // weight, source_value
    input  wire logic                         s_tlast,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [nws_pkg::M_DATA_W-1:0]      m_tdata,   // neuron_value, zero pad
    output logic [0:0]                        m_tuser    // sum_saturated
);

    localparam int SUM_FRAC  = 2 * FRAC_BITS;
    localparam int SEG_SHIFT = SUM_FRAC + 4;
    localparam int IDX_W     = $clog2(SIGMOID_SEGMENTS + 1);
    localparam int POS_W     = SEG_SHIFT + IDX_W;
    localparam longint unsigned SEG_STEP = (64'd16 << 30) / SIGMOID_SEGMENTS;
    localparam longint unsigned Q_STEP   = nws_pkg::exp_step(SEG_STEP);
    localparam longint signed   LIMIT    = 64'sd45 << SUM_FRAC;
    localparam logic [IDX_W-1:0] SEG_IDX = IDX_W'(SIGMOID_SEGMENTS);
    localparam nws_pkg::acc_t ACC_MAX = {1'b0, {(nws_pkg::ACC_W-1){1'b1}}};
    localparam nws_pkg::acc_t ACC_MIN = {1'b1, {(nws_pkg::ACC_W-1){1'b0}}};

    logic [nws_pkg::OUT_W-1:0] sig_rom [SIGMOID_SEGMENTS+1];

    for (genvar k = 0; k <= SIGMOID_SEGMENTS; k++) begin : g_rom
        localparam logic [nws_pkg::OUT_W-1:0] ENTRY = nws_pkg::sig_entry(Q_STEP, k);
        assign sig_rom[k] = ENTRY;
    end

    // multiply
    logic                            s_accept;
    logic signed [nws_pkg::IN_W-1:0] w_in;
    logic signed [nws_pkg::IN_W-1:0] v_in;
    nws_pkg::acc_t                   prod_next;
    nws_pkg::acc_t                   prod_reg;
    logic                            last1_reg;
    logic                            mac_vld_reg;

    assign s_accept  = s_tvalid && s_tready;
    assign w_in      = s_tdata[nws_pkg::IN_W-1:0];
    assign v_in      = s_tdata[2*nws_pkg::IN_W-1:nws_pkg::IN_W];
    assign prod_next = nws_pkg::ACC_W'(w_in) * nws_pkg::ACC_W'(v_in);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mac_vld_reg <= 1'b0;
        end else begin
            mac_vld_reg <= s_accept;
        end
        if (s_accept) begin
            prod_reg  <= prod_next;
            last1_reg <= s_tlast;
        end
    end

    // accumulate with saturation
    logic signed [nws_pkg::ACC_W:0] sum_wide;
    logic                           ovf;
    nws_pkg::acc_t                  sat_sum;
    nws_pkg::acc_t                  acc_reg;
    logic                           sat_reg;
    nws_pkg::acc_t                  fin_sum_reg;
    logic                           fin_sat_reg;
    logic                           fin_vld_reg;

    assign sum_wide = {acc_reg[nws_pkg::ACC_W-1], acc_reg}
                    + {prod_reg[nws_pkg::ACC_W-1], prod_reg};
    assign ovf      = sum_wide[nws_pkg::ACC_W] ^ sum_wide[nws_pkg::ACC_W-1];
    assign sat_sum  = ovf ? (sum_wide[nws_pkg::ACC_W] ? ACC_MIN : ACC_MAX)
                          : sum_wide[nws_pkg::ACC_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            sat_reg     <= 1'b0;
            fin_vld_reg <= 1'b0;
        end else begin
            fin_vld_reg <= mac_vld_reg && last1_reg;
            if (mac_vld_reg) begin
                if (last1_reg) begin
                    acc_reg <= '0;
                    sat_reg <= 1'b0;
                end else begin
                    acc_reg <= sat_sum;
                    sat_reg <= sat_reg | ovf;
                end
            end
        end
        if (mac_vld_reg && last1_reg) begin
            fin_sum_reg <= sat_sum;
            fin_sat_reg <= sat_reg | ovf;
        end
    end

    // range classify and magnitude
    logic signed [63:0]      fin_ext;
    logic [63:0]             mag;
    logic [SEG_SHIFT-1:0]    mag_reg;
    logic                    big_a_reg;
    nws_pkg::sig_flags_t     flags_a_reg;
    logic                    a_vld_reg;

    assign fin_ext = 64'(fin_sum_reg);
    assign mag     = fin_sum_reg[nws_pkg::ACC_W-1] ? 64'(-fin_ext) : 64'(fin_ext);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else begin
            a_vld_reg <= fin_vld_reg;
        end
        if (fin_vld_reg) begin
            mag_reg           <= mag[SEG_SHIFT-1:0];
            big_a_reg         <= |mag[63:SEG_SHIFT];
            flags_a_reg.below <= fin_ext < -LIMIT;
            flags_a_reg.above <= fin_ext > LIMIT;
            flags_a_reg.neg   <= fin_sum_reg[nws_pkg::ACC_W-1];
            flags_a_reg.sat   <= fin_sat_reg;
        end
    end

    // segment position
    logic [POS_W-1:0]    pos_reg;
    logic                big_b_reg;
    nws_pkg::sig_flags_t flags_b_reg;
    logic                b_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg <= 1'b0;
        end else begin
            b_vld_reg <= a_vld_reg;
        end
        if (a_vld_reg) begin
            pos_reg     <= POS_W'(mag_reg) * POS_W'(SIGMOID_SEGMENTS);
            big_b_reg   <= big_a_reg;
            flags_b_reg <= flags_a_reg;
        end
    end

    // table read
    logic [IDX_W-1:0]          seg_idx;
    logic [IDX_W-1:0]          rd0_addr;
    logic [IDX_W-1:0]          rd1_addr;
    logic [15:0]               r16;
    logic [nws_pkg::OUT_W-1:0] t0_reg;
    logic [nws_pkg::OUT_W-1:0] t1_reg;
    logic [15:0]               r16_reg;
    nws_pkg::sig_flags_t       flags_c_reg;
    logic                      c_vld_reg;

    assign seg_idx  = pos_reg[POS_W-1:SEG_SHIFT];
    assign rd0_addr = big_b_reg ? SEG_IDX : seg_idx;
    assign rd1_addr = big_b_reg ? SEG_IDX : seg_idx + 1'b1;
    assign r16      = big_b_reg ? 16'd0 : pos_reg[SEG_SHIFT-1 -: 16];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_vld_reg <= 1'b0;
        end else begin
            c_vld_reg <= b_vld_reg;
        end
        if (b_vld_reg) begin
            t0_reg      <= sig_rom[rd0_addr];
            t1_reg      <= sig_rom[rd1_addr];
            r16_reg     <= r16;
            flags_c_reg <= flags_b_reg;
        end
    end

    // interpolation product
    logic [nws_pkg::OUT_W-1:0] diff;
    logic [32:0]               frac_prod_reg;
    logic [nws_pkg::OUT_W-1:0] t0_d_reg;
    nws_pkg::sig_flags_t       flags_d_reg;
    logic                      d_vld_reg;

    assign diff = t1_reg - t0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_vld_reg <= 1'b0;
        end else begin
            d_vld_reg <= c_vld_reg;
        end
        if (c_vld_reg) begin
            frac_prod_reg <= 33'(diff) * 33'(r16_reg);
            t0_d_reg      <= t0_reg;
            flags_d_reg   <= flags_c_reg;
        end
    end

    // final value
    logic [32:0]               frac_round;
    logic [nws_pkg::OUT_W-1:0] interp;
    logic [nws_pkg::OUT_W-1:0] res_val;

    assign frac_round = frac_prod_reg + 33'd32768;
    assign interp     = t0_d_reg + frac_round[32:16];

    always_comb begin
        if (flags_d_reg.below) begin
            res_val = '0;
        end else if (flags_d_reg.above) begin
            res_val = nws_pkg::ONE_Q16;
        end else if (flags_d_reg.neg) begin
            res_val = nws_pkg::ONE_Q16 - interp;
        end else begin
            res_val = interp;
        end
    end

    // output register and skid entry
    logic                      out_fire;
    logic                      out_vld_reg,  out_vld_next;
    logic [nws_pkg::OUT_W-1:0] out_val_reg,  out_val_next;
    logic                      out_sat_reg,  out_sat_next;
    logic                      skid_vld_reg, skid_vld_next;
    logic [nws_pkg::OUT_W-1:0] skid_val_reg, skid_val_next;
    logic                      skid_sat_reg, skid_sat_next;
    logic                      busy_reg,     busy_next;

    assign out_fire = out_vld_reg && m_tready;

    always_comb begin
        out_vld_next  = out_vld_reg;
        out_val_next  = out_val_reg;
        out_sat_next  = out_sat_reg;
        skid_vld_next = skid_vld_reg;
        skid_val_next = skid_val_reg;
        skid_sat_next = skid_sat_reg;
        busy_next     = busy_reg;
        if (d_vld_reg && (!out_vld_reg || out_fire)) begin
            out_vld_next = 1'b1;
            out_val_next = res_val;
            out_sat_next = flags_d_reg.sat;
        end else if (d_vld_reg) begin
            skid_vld_next = 1'b1;
            skid_val_next = res_val;
            skid_sat_next = flags_d_reg.sat;
        end else if (out_fire) begin
            if (skid_vld_reg) begin
                out_val_next  = skid_val_reg;
                out_sat_next  = skid_sat_reg;
                skid_vld_next = 1'b0;
            end else begin
                out_vld_next = 1'b0;
            end
        end
        if (s_accept && s_tlast) begin
            busy_next = 1'b1;
        end else if (d_vld_reg) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
            busy_reg     <= 1'b0;
        end else begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
            busy_reg     <= busy_next;
        end
        out_val_reg  <= out_val_next;
        out_sat_reg  <= out_sat_next;
        skid_val_reg <= skid_val_next;
        skid_sat_reg <= skid_sat_next;
    end

    assign s_tready = !busy_reg && !skid_vld_reg;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = nws_pkg::M_DATA_W'(out_val_reg);
    assign m_tuser  = out_sat_reg;

endmodule

`default_nettype wire
